// ===== rtl/core/dsfo_pkg.sv =====
`default_nettype none

package dsfo_pkg;

    localparam int DEF_DEPTH      = 16;
    localparam int DEF_ITEM_WIDTH = 8;

    // widths fixed by the stream fields
    localparam int ITEM_IN_W = 8;
    localparam int FILL_W    = 5;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 16;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_UNDERFLOW = 2'd1,
        STAT_OVERFLOW  = 2'd2
    } status_t;

    // per-transaction control broadcast to every cell
    typedef struct packed {
        logic push;   // accepted push that changes the stack
        logic dup;    // an equal item is already held
        logic pop;    // accepted pop on a non-empty stack
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/dedup_stack_forget_old_core.sv =====
// A result appears on the master side in the cycle after its input transaction.
// Throughput: one push or pop per cycle while results are taken; each step is one
// compare pass and one shift through the row of cells.
// The input stalls only while a finished result is held and not taken.
// Reset (aresetn low at a clock edge) empties the stack and drops the pending result;
// stored entries are not cleared.
`default_nettype none

module dedup_stack_forget_old_core #(
    parameter int DEPTH      = dsfo_pkg::DEF_DEPTH,
    parameter int ITEM_WIDTH = dsfo_pkg::DEF_ITEM_WIDTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [dsfo_pkg::S_DATA_W-1:0] s_axis_tdata,  // [7:0] item_value
    input  wire logic                          s_axis_tuser,  // [0] action
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [7:0] popped_value, [9:8] status, [14:10] fill_count, [15] is_empty
    output logic [dsfo_pkg::M_DATA_W-1:0]      m_axis_tdata,
    output logic                               m_axis_tuser   // [0] pop_valid
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [dsfo_pkg::M_DATA_W-1:0] m_data_reg;
    logic [dsfo_pkg::M_DATA_W-1:0] m_data_next;
    logic             m_user_reg;
    logic             m_user_next;

    logic                  accept;
    logic                  is_pop;
    logic                  empty;
    logic                  full;
    logic                  dup;
    logic                  pop_ok;
    logic                  push_ok;
    logic                  push_new;
    logic [ITEM_WIDTH-1:0] item;
    logic [ITEM_WIDTH-1:0] cell_data [DEPTH];
    logic [ITEM_WIDTH-1:0] upper     [DEPTH];
    logic [ITEM_WIDTH-1:0] lower     [DEPTH];
    logic [DEPTH:0]        found;
    logic [DEPTH-1:0]      match_vec;
    dsfo_pkg::cell_ctrl_t  ctrl;
    dsfo_pkg::status_t     status;
    logic [dsfo_pkg::ITEM_IN_W-1:0] popped;
    logic [CNT_W-1:0]      count_after;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign item   = ITEM_WIDTH'(s_axis_tdata[dsfo_pkg::ITEM_IN_W-1:0]);
    assign is_pop = (s_axis_tuser == dsfo_pkg::ACT_POP);
    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CNT_W'(DEPTH));

    assign found[DEPTH] = 1'b0;
    assign dup          = found[0];

    assign pop_ok   = is_pop && !empty;
    assign push_new = !is_pop && !dup && !full;
    assign push_ok  = !is_pop && (dup || !full);

    assign ctrl.push = accept && push_ok;
    assign ctrl.dup  = dup;
    assign ctrl.pop  = accept && pop_ok;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_top
                assign upper[gi] = item;
            end else begin : g_mid
                assign upper[gi] = cell_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_bottom
                assign lower[gi] = cell_data[gi];
            end else begin : g_inner
                assign lower[gi] = cell_data[gi+1];
            end

            dsfo_cell #(
                .ITEM_WIDTH (ITEM_WIDTH),
                .CNT_W      (CNT_W),
                .INDEX      (gi)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .item       (item),
                .count      (count_reg),
                .from_upper (upper[gi]),
                .from_lower (lower[gi]),
                .found_in   (found[gi+1]),
                .found_out  (found[gi]),
                .match      (match_vec[gi]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (accept) begin
            if (pop_ok) begin
                count_next = count_reg - CNT_W'(1);
            end else if (push_new) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_comb begin
        status = dsfo_pkg::STAT_OK;
        if (is_pop && empty) begin
            status = dsfo_pkg::STAT_UNDERFLOW;
        end else if (!push_ok && !is_pop) begin
            status = dsfo_pkg::STAT_OVERFLOW;
        end
    end

    assign popped = pop_ok ? dsfo_pkg::ITEM_IN_W'(cell_data[0]) : '0;

    always_comb begin
        count_after = count_reg;
        if (pop_ok) begin
            count_after = count_reg - CNT_W'(1);
        end else if (push_new) begin
            count_after = count_reg + CNT_W'(1);
        end
    end

    // hold the result until taken; load a new one with each input transaction
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = {(count_after == '0),
                            dsfo_pkg::FILL_W'(count_after),
                            status,
                            popped};
            m_user_next  = pop_ok;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("stack count exceeds depth");

    a_no_duplicates: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_vec))
        else $error("stack holds two equal items");

    a_overflow_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (status == dsfo_pkg::STAT_OVERFLOW) |=> $stable(count_reg))
        else $error("dropped push changed the count");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && pop_ok |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not decrement the count");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_valid_reg && !m_axis_tready)
        else $error("input stalled without a pending result");

endmodule

`default_nettype wire

// ===== rtl/core/dsfo_cell.sv =====
`default_nettype none

module dsfo_cell #(
    parameter int ITEM_WIDTH = dsfo_pkg::DEF_ITEM_WIDTH,
    parameter int CNT_W      = 5,
    parameter int INDEX      = 0
) (
    input  wire logic                  aclk,
    input  wire dsfo_pkg::cell_ctrl_t  ctrl,
    input  wire logic [ITEM_WIDTH-1:0] item,
    input  wire logic [CNT_W-1:0]      count,
    input  wire logic [ITEM_WIDTH-1:0] from_upper,  // neighbor nearer the top
    input  wire logic [ITEM_WIDTH-1:0] from_lower,  // neighbor nearer the bottom
    input  wire logic                  found_in,    // match in a deeper cell
    output logic                       found_out,
    output logic                       match,
    output logic [ITEM_WIDTH-1:0]      data
);

    logic [ITEM_WIDTH-1:0] data_reg;
    logic [ITEM_WIDTH-1:0] data_next;
    logic                  occupied;
    logic                  move_down;

    // cell 0 is the top of the stack
    assign occupied  = count > CNT_W'(INDEX);
    assign match     = occupied && (data_reg == item);
    assign found_out = found_in | match;

    // on a duplicate only the cells from the top down to the old copy move
    assign move_down = ctrl.push && (!ctrl.dup || found_out);

    always_comb begin
        data_next = data_reg;
        if (move_down) begin
            data_next = from_upper;
        end else if (ctrl.pop) begin
            data_next = from_lower;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire
